FILE: hw/rtl/mstt_pkg.sv
// Shared types, codes and sizing constants for the periodic timer slot table.
// Used by mstt_ctrl and multi_slot_periodic_timer_table_top; no dependencies.
`default_nettype none
package mstt_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int MAX_SLOTS       = 16;
  localparam int CMD_W           = 3;
  localparam int SLOT_W          = 4;
  localparam int VAL_W           = 16;
  localparam int KIND_W          = 2;
  localparam int STAT_W          = 2;
  localparam int COUNT_W         = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_REGISTER   = 3'd1,
    CMD_SUSPEND    = 3'd2,
    CMD_RESUME     = 3'd3,
    CMD_UNREGISTER = 3'd4,
    CMD_RESET      = 3'd5,
    CMD_MODIFY     = 3'd6
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_RESP  = 2'd0,
    KIND_FIRE  = 2'd1,
    KIND_QUIET = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_UNUSED  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_TICK,
    ST_TICK_END
  } state_t;

  typedef struct packed {
    logic auto_unreg;
    logic susp;
    logic used;
  } flags_t;

  typedef struct packed {
    logic        [VAL_W-1:0] interval;
    logic        [VAL_W-1:0] remaining;
    logic signed [VAL_W-1:0] iterations;
    logic signed [VAL_W-1:0] total;
  } slot_data_t;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic              stopped;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/mstt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mstt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/mstt_ctrl.sv
// Command sequencer for the timer slot table: slot flags, use count, the tick
// scan over the slot RAM and result formation. Depends on mstt_pkg.
`default_nettype none
module mstt_ctrl #(
  parameter int NSLOTS = mstt_pkg::TIMER_SLOTS_DEF,
  localparam int AW = (NSLOTS > 1) ? $clog2(NSLOTS) : 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [mstt_pkg::CMD_W-1:0]     in_command,
  input  wire logic [mstt_pkg::SLOT_W-1:0]    in_slot,
  input  wire logic [mstt_pkg::VAL_W-1:0]     in_interval,
  input  wire logic signed [mstt_pkg::VAL_W-1:0] in_iterations,
  input  wire logic                           in_auto_unregister,
  output logic                                mem_re,
  output logic [AW-1:0]                       mem_raddr,
  output logic                                mem_we,
  output logic [AW-1:0]                       mem_waddr,
  output mstt_pkg::slot_data_t                mem_wdata,
  input  wire mstt_pkg::slot_data_t           mem_rdata,
  output mstt_pkg::res_t                      res
);

  mstt_pkg::state_t state_r, state_nxt;
  mstt_pkg::flags_t flags_r [NSLOTS];
  mstt_pkg::flags_t flags_nxt [NSLOTS];
  logic [mstt_pkg::COUNT_W-1:0] used_r, used_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic held_vld_r, held_vld_nxt;
  logic [mstt_pkg::SLOT_W-1:0] held_slot_r, held_slot_nxt;
  logic held_stop_r, held_stop_nxt;

  logic [mstt_pkg::CMD_W-1:0]  cmd_r;
  logic [mstt_pkg::SLOT_W-1:0] slot_r;
  logic [mstt_pkg::VAL_W-1:0]  ival_r;
  logic signed [mstt_pkg::VAL_W-1:0] iters_r;
  logic                        auto_r;

  logic accept;
  logic [AW-1:0] free_idx;
  logic slot_ok;
  logic [AW-1:0] tgt;
  mstt_pkg::flags_t tick_f;
  logic signed [mstt_pkg::VAL_W-1:0] it_dec;

  assign accept = start && (state_r == mstt_pkg::ST_IDLE);
  assign busy   = (state_r != mstt_pkg::ST_IDLE);
  assign tgt    = slot_r[AW-1:0];
  assign slot_ok = ({1'b0, slot_r} < (mstt_pkg::SLOT_W+1)'(NSLOTS)) && flags_r[tgt].used;
  assign tick_f = flags_r[cnt_r];

  // First unused slot, lowest index wins.
  always_comb begin
    free_idx = '0;
    for (int k = NSLOTS - 1; k >= 0; k--) begin
      if (!flags_r[k].used) begin
        free_idx = AW'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_command;
      slot_r  <= in_slot;
      ival_r  <= in_interval;
      iters_r <= in_iterations;
      auto_r  <= in_auto_unregister;
    end
    held_slot_r <= held_slot_nxt;
    held_stop_r <= held_stop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mstt_pkg::ST_IDLE;
      used_r     <= '0;
      cnt_r      <= '0;
      held_vld_r <= 1'b0;
      for (int k = 0; k < NSLOTS; k++) begin
        flags_r[k] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      cnt_r      <= cnt_nxt;
      held_vld_r <= held_vld_nxt;
      flags_r    <= flags_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    flags_nxt     = flags_r;
    used_nxt      = used_r;
    cnt_nxt       = cnt_r;
    held_vld_nxt  = held_vld_r;
    held_slot_nxt = held_slot_r;
    held_stop_nxt = held_stop_r;
    mem_re        = 1'b0;
    mem_raddr     = in_slot[AW-1:0];
    mem_we        = 1'b0;
    mem_waddr     = tgt;
    mem_wdata     = mem_rdata;
    it_dec        = mem_rdata.iterations;
    res           = '0;
    res.last      = 1'b1;

    unique case (state_r)
      mstt_pkg::ST_IDLE: begin
        if (accept) begin
          mem_re = 1'b1;
          if (in_command == mstt_pkg::CMD_TICK) begin
            mem_raddr    = '0;
            cnt_nxt      = '0;
            held_vld_nxt = 1'b0;
            state_nxt    = mstt_pkg::ST_TICK;
          end else begin
            state_nxt = mstt_pkg::ST_CMD;
          end
        end
      end

      mstt_pkg::ST_CMD: begin
        res.valid  = 1'b1;
        res.kind   = mstt_pkg::KIND_RESP;
        res.status = mstt_pkg::STAT_OK;
        res.slot   = slot_r;
        state_nxt  = mstt_pkg::ST_IDLE;
        case (cmd_r)
          mstt_pkg::CMD_REGISTER: begin
            if (used_r >= mstt_pkg::COUNT_W'(NSLOTS)) begin
              res.status = mstt_pkg::STAT_NOSPACE;
              res.slot   = '0;
            end else begin
              flags_nxt[free_idx] = '{auto_unreg: auto_r, susp: 1'b1, used: 1'b1};
              mem_we    = 1'b1;
              mem_waddr = free_idx;
              mem_wdata = '{interval: ival_r, remaining: ival_r,
                            iterations: iters_r, total: iters_r};
              used_nxt  = used_r + 1'b1;
              res.slot  = mstt_pkg::SLOT_W'(free_idx);
            end
          end
          mstt_pkg::CMD_SUSPEND, mstt_pkg::CMD_RESUME, mstt_pkg::CMD_UNREGISTER,
          mstt_pkg::CMD_RESET, mstt_pkg::CMD_MODIFY: begin
            if (!slot_ok) begin
              res.status = mstt_pkg::STAT_UNUSED;
            end else begin
              case (cmd_r)
                mstt_pkg::CMD_SUSPEND:    flags_nxt[tgt].susp = 1'b1;
                mstt_pkg::CMD_RESUME:     flags_nxt[tgt].susp = 1'b0;
                mstt_pkg::CMD_UNREGISTER: begin
                  flags_nxt[tgt] = '0;
                  if (used_r != '0) begin
                    used_nxt = used_r - 1'b1;
                  end
                end
                mstt_pkg::CMD_RESET: begin
                  mem_we    = 1'b1;
                  mem_wdata = '{interval: mem_rdata.interval,
                                remaining: mem_rdata.interval,
                                iterations: mem_rdata.total,
                                total: mem_rdata.total};
                end
                default: begin
                  mem_we    = 1'b1;
                  mem_wdata = '{interval: ival_r, remaining: ival_r,
                                iterations: iters_r, total: iters_r};
                end
              endcase
            end
          end
          default: ;
        endcase
      end

      mstt_pkg::ST_TICK: begin
        // Prefetch the next slot while this one is updated.
        mem_re    = (cnt_r != AW'(NSLOTS - 1));
        mem_raddr = cnt_r + 1'b1;
        mem_waddr = cnt_r;
        if (tick_f.used && !tick_f.susp) begin
          mem_we = 1'b1;
          if (mem_rdata.remaining > mstt_pkg::VAL_W'(1)) begin
            mem_wdata.remaining = mem_rdata.remaining - 1'b1;
          end else begin
            mem_wdata.remaining = mem_rdata.interval;
            if (mem_rdata.iterations > 0) begin
              it_dec = mem_rdata.iterations - 1'b1;
            end
            mem_wdata.iterations = it_dec;
            held_stop_nxt = 1'b0;
            if (it_dec == '0) begin
              held_stop_nxt = 1'b1;
              if (tick_f.auto_unreg) begin
                flags_nxt[cnt_r] = '0;
                if (used_r != '0) begin
                  used_nxt = used_r - 1'b1;
                end
              end else begin
                flags_nxt[cnt_r].susp = 1'b1;
                mem_wdata.iterations  = mem_rdata.total;
              end
            end
            if (held_vld_r) begin
              res.valid   = 1'b1;
              res.kind    = mstt_pkg::KIND_FIRE;
              res.slot    = held_slot_r;
              res.stopped = held_stop_r;
              res.last    = 1'b0;
            end
            held_vld_nxt  = 1'b1;
            held_slot_nxt = mstt_pkg::SLOT_W'(cnt_r);
          end
        end
        if (cnt_r == AW'(NSLOTS - 1)) begin
          state_nxt = mstt_pkg::ST_TICK_END;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      mstt_pkg::ST_TICK_END: begin
        res.valid = 1'b1;
        if (held_vld_r) begin
          res.kind    = mstt_pkg::KIND_FIRE;
          res.slot    = held_slot_r;
          res.stopped = held_stop_r;
        end else begin
          res.kind = mstt_pkg::KIND_QUIET;
        end
        held_vld_nxt = 1'b0;
        state_nxt    = mstt_pkg::ST_IDLE;
      end

      default: state_nxt = mstt_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/multi_slot_periodic_timer_table_top.sv
// Top level of the periodic timer slot table: sequencer, slot RAM and output
// register. Depends on mstt_pkg, mstt_ram and mstt_ctrl.
`default_nettype none
// Usage
//   Input channel: drive in_* and raise start; the word is taken at a rising
//   edge where start is high and busy is low. busy stays high while a word
//   is in progress.
//   Result channel: each result word sits on out_* for exactly one cycle with
//   out_valid high; the receiver cannot stall, so no backpressure exists.
//   out_last marks the final result word of an input word.
// Timing
//   Commands other than tick: the sequencer forms the result word in its
//   command state and the output register then puts it on out_*; busy is
//   high only in that state, and a new word may be taken once it falls.
//   Tick: the sequencer walks the slot RAM one slot per cycle, prefetching
//   the next slot while writing back the current one; busy stays high
//   through the scan and its end state. Fire words come out as slots
//   expire; one is held back so the final one can carry out_last, or a
//   quiet-tick word is sent when nothing fired.
// Reset
//   rst_n low (synchronous) marks every slot unused and clears the use count;
//   slot RAM contents are only used after a register command writes them.
module multi_slot_periodic_timer_table_top #(
  parameter int TIMER_SLOTS = mstt_pkg::TIMER_SLOTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [mstt_pkg::CMD_W-1:0]        in_command,
  input  wire logic [mstt_pkg::SLOT_W-1:0]       in_slot,
  input  wire logic [mstt_pkg::VAL_W-1:0]        in_interval,
  input  wire logic signed [mstt_pkg::VAL_W-1:0] in_iterations,
  input  wire logic                              in_auto_unregister,
  output logic                                   out_valid,
  output logic [mstt_pkg::KIND_W-1:0]            out_kind,
  output logic [mstt_pkg::STAT_W-1:0]            out_status,
  output logic [mstt_pkg::SLOT_W-1:0]            out_slot_out,
  output logic                                   out_stopped,
  output logic                                   out_last
);

  // Slot field is four bits wide: clamp the table to what it can address.
  localparam int NSLOTS = (TIMER_SLOTS > mstt_pkg::MAX_SLOTS) ? mstt_pkg::MAX_SLOTS :
                          ((TIMER_SLOTS < 1) ? 1 : TIMER_SLOTS);
  localparam int AW = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;

  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  mstt_pkg::slot_data_t mem_wdata;
  mstt_pkg::slot_data_t mem_rdata;
  mstt_pkg::res_t       res;

  logic                            out_valid_r;
  logic [mstt_pkg::KIND_W-1:0]     out_kind_r;
  logic [mstt_pkg::STAT_W-1:0]     out_status_r;
  logic [mstt_pkg::SLOT_W-1:0]     out_slot_r;
  logic                            out_stopped_r;
  logic                            out_last_r;

  mstt_ctrl #(
    .NSLOTS (NSLOTS)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_slot            (in_slot),
    .in_interval        (in_interval),
    .in_iterations      (in_iterations),
    .in_auto_unregister (in_auto_unregister),
    .mem_re             (mem_re),
    .mem_raddr          (mem_raddr),
    .mem_we             (mem_we),
    .mem_waddr          (mem_waddr),
    .mem_wdata          (mem_wdata),
    .mem_rdata          (mem_rdata),
    .res                (res)
  );

  // Interval, countdown, iteration count and restore count per slot.
  mstt_ram #(
    .WIDTH ($bits(mstt_pkg::slot_data_t)),
    .DEPTH (NSLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Register the result word; the strobe is the only control bit to reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.valid;
    end
    out_kind_r    <= res.kind;
    out_status_r  <= res.status;
    out_slot_r    <= res.slot;
    out_stopped_r <= res.stopped;
    out_last_r    <= res.last;
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_status   = out_status_r;
  assign out_slot_out = out_slot_r;
  assign out_stopped  = out_stopped_r;
  assign out_last     = out_last_r;

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking bench for multi_slot_periodic_timer_table_top: directed and random
// command words, with a built-in predictor of the slot table and in-order result checks.
// Depends on mstt_pkg and the top-level RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mstt_pkg::*;

  localparam int NSLOTS = TIMER_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_WORDS = 250;
  // Command code 7 is outside cmd_t; the block echoes it back as a plain response.
  localparam logic [CMD_W-1:0] CMD_UNDEF = 3'd7;

  // One input word plus its pacing: idle cycles before it and an optional
  // drain of all outstanding results before it goes out.
  typedef struct {
    logic [CMD_W-1:0]        command;
    logic [SLOT_W-1:0]       slot;
    logic [VAL_W-1:0]        interval;
    logic signed [VAL_W-1:0] iterations;
    logic                    auto_unreg;
    int unsigned             gap;
    bit                      drain;
  } timer_cmd_t;

  typedef struct {
    kind_t             kind;
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic              stopped;
    logic              last;
  } timer_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] in_command = '0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic [VAL_W-1:0] in_interval = '0;
  logic signed [VAL_W-1:0] in_iterations = '0;
  logic in_auto_unregister = 1'b0;
  logic out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [STAT_W-1:0] out_status;
  logic [SLOT_W-1:0] out_slot_out;
  logic out_stopped;
  logic out_last;

  // Stimulus and scoreboard state.
  timer_cmd_t cmd_queue[$];
  timer_cmd_t on_bus;
  timer_word_t due_words[$];
  bit took = 1'b0;
  int unsigned gap_count = 0;
  int n_items = 0;
  int n_taken = 0;
  int errors = 0;
  int cycle_count = 0;

  // Predicted slot table.
  flags_t slot_flags[NSLOTS];
  logic [VAL_W-1:0] slot_ival[NSLOTS];
  logic [VAL_W-1:0] slot_left[NSLOTS];
  logic signed [VAL_W-1:0] slot_iters[NSLOTS];
  logic signed [VAL_W-1:0] slot_total[NSLOTS];
  int used_slots = 0;

  multi_slot_periodic_timer_table_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_slot           (in_slot),
    .in_interval       (in_interval),
    .in_iterations     (in_iterations),
    .in_auto_unregister(in_auto_unregister),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_status        (out_status),
    .out_slot_out      (out_slot_out),
    .out_stopped       (out_stopped),
    .out_last          (out_last)
  );

  always #5 clk = ~clk;

  function automatic void push_word(kind_t k, status_t s, logic [SLOT_W-1:0] sl,
                                    logic stp, logic lst);
    timer_word_t w;
    w.kind = k;
    w.status = s;
    w.slot = sl;
    w.stopped = stp;
    w.last = lst;
    due_words.push_back(w);
  endfunction

  // Release a slot: clear its flags and data and drop the use count.
  function automatic void free_timer_slot(int i);
    slot_flags[i] = '0;
    slot_ival[i] = '0;
    slot_left[i] = '0;
    slot_iters[i] = '0;
    slot_total[i] = '0;
    if (used_slots > 0) used_slots--;
  endfunction

  // Apply one accepted word to the predicted table and queue the result
  // words it must produce, in order.
  function automatic void advance_timer_table(timer_cmd_t c);
    int fired;
    int free_idx;
    logic stp;
    timer_word_t w;
    fired = 0;
    free_idx = -1;
    if (c.command == CMD_TICK) begin
      // Walk the slots in order; only used, running slots count down.
      for (int i = 0; i < NSLOTS; i++) begin
        if (!slot_flags[i].used || slot_flags[i].susp) continue;
        if (slot_left[i] > 1) begin
          slot_left[i]--;
          continue;
        end
        slot_left[i] = slot_ival[i];
        if (slot_iters[i] > 0) slot_iters[i]--;
        stp = (slot_iters[i] == 0);
        if (stp) begin
          if (slot_flags[i].auto_unreg) begin
            free_timer_slot(i);
          end else begin
            slot_flags[i].susp = 1'b1;
            slot_iters[i] = slot_total[i];
          end
        end
        push_word(KIND_FIRE, STAT_OK, SLOT_W'(i), stp, 1'b0);
        fired++;
      end
      if (fired == 0) begin
        push_word(KIND_QUIET, STAT_OK, '0, 1'b0, 1'b1);
      end else begin
        // Mark the final fire word of this tick.
        w = due_words.pop_back();
        w.last = 1'b1;
        due_words.push_back(w);
      end
    end else if (c.command == CMD_REGISTER) begin
      for (int i = NSLOTS - 1; i >= 0; i--) begin
        if (!slot_flags[i].used) free_idx = i;
      end
      if (used_slots >= NSLOTS || free_idx < 0) begin
        push_word(KIND_RESP, STAT_NOSPACE, '0, 1'b0, 1'b1);
      end else begin
        slot_flags[free_idx].used = 1'b1;
        slot_flags[free_idx].susp = 1'b1;
        slot_flags[free_idx].auto_unreg = c.auto_unreg;
        slot_ival[free_idx] = c.interval;
        slot_left[free_idx] = c.interval;
        slot_iters[free_idx] = c.iterations;
        slot_total[free_idx] = c.iterations;
        used_slots++;
        push_word(KIND_RESP, STAT_OK, SLOT_W'(free_idx), 1'b0, 1'b1);
      end
    end else if (c.command == CMD_UNDEF) begin
      push_word(KIND_RESP, STAT_OK, c.slot, 1'b0, 1'b1);
    end else if (!slot_flags[c.slot].used) begin
      push_word(KIND_RESP, STAT_UNUSED, c.slot, 1'b0, 1'b1);
    end else begin
      case (c.command)
        CMD_SUSPEND: slot_flags[c.slot].susp = 1'b1;
        CMD_RESUME: slot_flags[c.slot].susp = 1'b0;
        CMD_UNREGISTER: free_timer_slot(int'(c.slot));
        CMD_RESET: begin
          slot_iters[c.slot] = slot_total[c.slot];
          slot_left[c.slot] = slot_ival[c.slot];
        end
        CMD_MODIFY: begin
          slot_iters[c.slot] = c.iterations;
          slot_total[c.slot] = c.iterations;
          slot_ival[c.slot] = c.interval;
          slot_left[c.slot] = c.interval;
        end
        default: ;
      endcase
      push_word(KIND_RESP, STAT_OK, c.slot, 1'b0, 1'b1);
    end
  endfunction

  function automatic timer_cmd_t make_cmd(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] sl,
                                          logic [VAL_W-1:0] ival,
                                          logic signed [VAL_W-1:0] iters, logic au);
    timer_cmd_t c;
    c.command = cmd;
    c.slot = sl;
    c.interval = ival;
    c.iterations = iters;
    c.auto_unreg = au;
    c.gap = 0;
    c.drain = 1'b0;
    return c;
  endfunction

  // Random word: short intervals and few iterations so slots fire and stop
  // often, with occasional full-range values and targets mostly in the low
  // slots, where registers land.
  function automatic timer_cmd_t random_cmd();
    timer_cmd_t c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    c.slot = ($urandom_range(0, 3) == 0) ? SLOT_W'($urandom) : SLOT_W'($urandom_range(0, 7));
    c.interval = ($urandom_range(0, 9) == 0) ? VAL_W'($urandom) : VAL_W'($urandom_range(0, 4));
    case ($urandom_range(0, 9))
      0: c.iterations = 16'hFFFF;
      1: c.iterations = 16'h8000 | VAL_W'($urandom);
      2: c.iterations = '0;
      3: c.iterations = VAL_W'($urandom_range(5, 32767));
      default: c.iterations = VAL_W'($urandom_range(1, 4));
    endcase
    c.auto_unreg = 1'($urandom_range(0, 1));
    if (pick < 40) c.command = CMD_TICK;
    else if (pick < 55) c.command = CMD_REGISTER;
    else if (pick < 70) c.command = CMD_RESUME;
    else if (pick < 75) c.command = CMD_SUSPEND;
    else if (pick < 83) c.command = CMD_UNREGISTER;
    else if (pick < 89) c.command = CMD_RESET;
    else if (pick < 97) c.command = CMD_MODIFY;
    else c.command = CMD_UNDEF;
    c.gap = 0;
    c.drain = 1'b0;
    return c;
  endfunction

  // Driver: change inputs on the falling edge. Hold the current word until it
  // is taken, then idle for the next word's gap (and drain, if asked) before
  // raising start again. start stays high across back-to-back words.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took) begin
      took = 1'b0;
      if (cmd_queue.size() == 0) begin
        start <= 1'b0;
      end else if (gap_count < cmd_queue[0].gap) begin
        start <= 1'b0;
        gap_count++;
      end else if (cmd_queue[0].drain && due_words.size() != 0) begin
        start <= 1'b0;
      end else begin
        on_bus = cmd_queue.pop_front();
        in_command <= on_bus.command;
        in_slot <= on_bus.slot;
        in_interval <= on_bus.interval;
        in_iterations <= on_bus.iterations;
        in_auto_unregister <= on_bus.auto_unreg;
        start <= 1'b1;
        gap_count = 0;
      end
    end
  end

  // Monitor: on the rising edge, check any result word against the oldest
  // expectation, then feed an accepted word to the predictor.
  always @(posedge clk) begin : watch
    timer_word_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (due_words.size() == 0) begin
          $error("unexpected result word: kind %0d status %0d slot %0d", out_kind,
                 out_status, out_slot_out);
          errors++;
        end else begin
          want = due_words.pop_front();
          if (out_kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_kind);
            errors++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_slot_out !== want.slot) begin
            $error("slot_out: expected %0d, got %0d", want.slot, out_slot_out);
            errors++;
          end
          if (out_stopped !== want.stopped) begin
            $error("stopped: expected %0d, got %0d", want.stopped, out_stopped);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        advance_timer_table(on_bus);
        took = 1'b1;
        n_taken++;
      end
    end
  end

  // Watchdog: give up well past the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    timer_cmd_t c;
    logic signed [VAL_W-1:0] iters;
    for (int i = 0; i < NSLOTS; i++) begin
      slot_flags[i] = '0;
      slot_ival[i] = '0;
      slot_left[i] = '0;
      slot_iters[i] = '0;
      slot_total[i] = '0;
    end

    // Directed part: quiet tick on an empty table, a command on an unused
    // slot, the undefined code, then fill the table with extreme settings.
    cmd_queue.push_back(make_cmd(CMD_TICK, 4'hF, 16'hFFFF, 16'hFFFF, 1'b1));
    cmd_queue.push_back(make_cmd(CMD_MODIFY, 4'd0, 16'd7, 16'sd3, 1'b0));
    cmd_queue.push_back(make_cmd(CMD_UNDEF, 4'hF, 16'h0, 16'sd0, 1'b0));
    for (int i = 0; i < NSLOTS; i++) begin
      case (i)
        0: iters = 16'hFFFF;
        1: iters = 16'sd2;
        3: iters = 16'sd0;
        4: iters = 16'sh7FFF;
        5: iters = 16'sh8000;
        default: iters = 16'sd1;
      endcase
      cmd_queue.push_back(make_cmd(CMD_REGISTER, SLOT_W'(NSLOTS - 1 - i),
                                   (i == 2) ? 16'hFFFF : VAL_W'(i % 3), iters, i[0]));
    end
    // Table is full now.
    cmd_queue.push_back(make_cmd(CMD_REGISTER, 4'd0, 16'd1, 16'sd1, 1'b0));
    // Run a forever slot, an auto-freeing slot and a zero-iteration slot.
    cmd_queue.push_back(make_cmd(CMD_RESUME, 4'd0, 16'd0, 16'sd0, 1'b0));
    cmd_queue.push_back(make_cmd(CMD_RESUME, 4'd1, 16'd0, 16'sd0, 1'b0));
    cmd_queue.push_back(make_cmd(CMD_RESUME, 4'd3, 16'd0, 16'sd0, 1'b0));
    cmd_queue.push_back(make_cmd(CMD_TICK, 4'd0, 16'd0, 16'sd0, 1'b0));
    cmd_queue.push_back(make_cmd(CMD_TICK, 4'd0, 16'd0, 16'sd0, 1'b0));
    cmd_queue.push_back(make_cmd(CMD_MODIFY, 4'd0, 16'd1, 16'sd3, 1'b1));
    cmd_queue.push_back(make_cmd(CMD_RESET, 4'd2, 16'd0, 16'sd0, 1'b0));
    cmd_queue.push_back(make_cmd(CMD_SUSPEND, 4'd0, 16'd0, 16'sd0, 1'b0));
    cmd_queue.push_back(make_cmd(CMD_UNREGISTER, 4'd15, 16'd0, 16'sd0, 1'b0));
    cmd_queue.push_back(make_cmd(CMD_TICK, 4'd0, 16'd0, 16'sd0, 1'b0));

    // Random part; pause for a full drain now and then.
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      c = random_cmd();
      c.drain = (k % 50 == 0);
      cmd_queue.push_back(c);
    end

    // Pace the words: every third stretch of 25 goes back to back.
    foreach (cmd_queue[k]) begin
      cmd_queue[k].gap = ((k / 25) % 3 == 1) ? 0 : $urandom_range(0, 19);
    end
    n_items = cmd_queue.size();

    // Hold reset at the start, then release it on a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (n_taken == n_items);
    while (due_words.size() != 0) @(posedge clk);
    // Let any stray words show up before closing.
    repeat (2 * NSLOTS + 8) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
